// File: hw/rtl/bmsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsa_pkg
// Shared types and codes for the bus memory slave with atomics.
// ----------------------------------------------------------------------------
package bmsa_pkg;

  // request kinds
  localparam logic [2:0] KIND_PUT_FULL    = 3'd0;
  localparam logic [2:0] KIND_PUT_PARTIAL = 3'd1;
  localparam logic [2:0] KIND_ARITH       = 3'd2;
  localparam logic [2:0] KIND_LOGIC       = 3'd3;
  localparam logic [2:0] KIND_GET         = 3'd4;
  localparam logic [2:0] KIND_INTENT      = 3'd5;

  // arithmetic atomic ops
  localparam logic [2:0] ARITH_MIN  = 3'd0;
  localparam logic [2:0] ARITH_MAX  = 3'd1;
  localparam logic [2:0] ARITH_MINU = 3'd2;
  localparam logic [2:0] ARITH_MAXU = 3'd3;
  localparam logic [2:0] ARITH_ADD  = 3'd4;

  // logical atomic ops
  localparam logic [2:0] LOGIC_XOR  = 3'd0;
  localparam logic [2:0] LOGIC_OR   = 3'd1;
  localparam logic [2:0] LOGIC_AND  = 3'd2;
  localparam logic [2:0] LOGIC_SWAP = 3'd3;

  // response kinds
  localparam logic [1:0] RESP_ACK      = 2'd0;
  localparam logic [1:0] RESP_ACK_DATA = 2'd1;
  localparam logic [1:0] RESP_HINT_ACK = 2'd2;

  // misc constants
  localparam logic [30:0] ADDR_STEP      = 31'd8;
  localparam logic [7:0]  LOW_LANES_MASK = 8'h0f;

  // request word
  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  op_param;
    logic [2:0]  size_log2;
    logic [7:0]  source_id;
    logic [31:0] byte_address;
    logic [7:0]  byte_mask;
    logic [63:0] beat_data;
  } req_t;

  // response word
  typedef struct packed {
    logic [1:0]  resp_kind;
    logic [2:0]  resp_size;
    logic [7:0]  resp_source;
    logic [63:0] resp_data;
    logic        last_beat;
  } resp_t;

  // command classes handed from front to back
  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_ATOMIC,
    CMD_READ,
    CMD_HINT
  } cmd_op_t;

  // command word
  typedef struct packed {
    cmd_op_t     op;
    logic        arith;
    logic [2:0]  param;
    logic [2:0]  size;
    logic [7:0]  source;
    logic [30:0] offset;
    logic [7:0]  mask;
    logic [63:0] data;
    logic        last;
    logic [3:0]  beats;
  } cmd_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC
  } back_state_t;

endpackage

// File: hw/rtl/bmsa_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsa_fifo
// Small synchronous queue of fixed-width words with full and empty flags.
// ----------------------------------------------------------------------------
module bmsa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_ONE   = PTR_W'(1);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == DEPTH_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_ONE;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_ONE;
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_ONE;
      end else if (do_pop && !do_push) begin
        count <= count - CNT_ONE;
      end
    end
  end

endmodule

// File: hw/rtl/bmsa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsa_front
// Request front end: latches headers, tracks bursts, classifies each word.
// ----------------------------------------------------------------------------
module bmsa_front
  import bmsa_pkg::*;
#(
  parameter int MAX_SIZE_LOG2 = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  req_t        req,
  output logic        full,
  input  logic [30:0] base_address,
  input  logic        cmd_full,
  output logic        cmd_push,
  output cmd_t        cmd
);

  localparam int          CLAMP   = (MAX_SIZE_LOG2 > 7) ? 7 : MAX_SIZE_LOG2;
  localparam logic [2:0]  CLAMP_S = 3'(CLAMP);

  logic [30:0] burst_address;
  logic [30:0] burst_address_next;
  logic [3:0]  beats_left;
  logic [3:0]  beats_left_next;
  logic [2:0]  held_kind;
  logic [2:0]  held_param;
  logic [2:0]  held_size;
  logic [7:0]  held_source;

  logic        accept;
  logic        header;
  logic        known;
  logic [2:0]  cur_kind;
  logic [2:0]  cur_param;
  logic [2:0]  cur_size;
  logic [7:0]  cur_source;
  logic [30:0] cur_addr;
  logic [3:0]  cur_beats;
  logic [2:0]  size_cl;
  logic [3:0]  header_beats;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;
  assign header = (beats_left == '0);
  assign known  = (req.kind <= KIND_INTENT);

  // burst length from clamped size
  always_comb begin
    size_cl = (req.size_log2 > CLAMP_S) ? CLAMP_S : req.size_log2;
    unique case (size_cl)
      3'd4:    header_beats = 4'd2;
      3'd5:    header_beats = 4'd4;
      3'd6,
      3'd7:    header_beats = 4'd8;
      default: header_beats = 4'd1;
    endcase
  end

  // header or held fields for this word
  always_comb begin
    if (header) begin
      cur_kind   = req.kind;
      cur_param  = req.op_param;
      cur_size   = req.size_log2;
      cur_source = req.source_id;
      cur_addr   = req.byte_address[30:0];
      cur_beats  = header_beats;
    end else begin
      cur_kind   = held_kind;
      cur_param  = held_param;
      cur_size   = held_size;
      cur_source = held_source;
      cur_addr   = burst_address;
      cur_beats  = beats_left;
    end
  end

  // classify the word into a command
  always_comb begin
    cmd_push           = accept && (!header || known);
    cmd.arith          = (cur_kind == KIND_ARITH);
    cmd.param          = cur_param;
    cmd.size           = cur_size;
    cmd.source         = cur_source;
    cmd.offset         = cur_addr - base_address;
    cmd.mask           = req.byte_mask;
    cmd.data           = req.beat_data;
    cmd.last           = (cur_beats == 4'd1);
    cmd.beats          = cur_beats;
    beats_left_next    = beats_left;
    burst_address_next = burst_address;
    priority case (cur_kind)
      KIND_GET: begin
        cmd.op = CMD_READ;
      end
      KIND_INTENT: begin
        cmd.op = CMD_HINT;
      end
      KIND_PUT_FULL, KIND_PUT_PARTIAL: begin
        cmd.op = CMD_WRITE;
      end
      default: begin
        cmd.op = CMD_ATOMIC;
      end
    endcase
    if (cmd_push) begin
      burst_address_next = cur_addr + ADDR_STEP;
      if (cmd.op == CMD_WRITE || cmd.op == CMD_ATOMIC) begin
        beats_left_next = cur_beats - 4'd1;
      end else begin
        beats_left_next = '0;
      end
    end
  end

  // burst tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_address <= '0;
      beats_left    <= '0;
      held_kind     <= '0;
      held_param    <= '0;
      held_size     <= '0;
      held_source   <= '0;
    end else begin
      burst_address <= burst_address_next;
      beats_left    <= beats_left_next;
      if (cmd_push && header) begin
        held_kind   <= cur_kind;
        held_param  <= cur_param;
        held_size   <= cur_size;
        held_source <= cur_source;
      end
    end
  end

endmodule

// File: hw/rtl/bmsa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsa_back
// Execution back end: word store, atomic unit and beat sequencer.
// ----------------------------------------------------------------------------
module bmsa_back
  import bmsa_pkg::*;
#(
  parameter int MEM_WORDS = 4096
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_empty,
  input  cmd_t  cmd_in,
  output logic  cmd_pop,
  input  logic  rsp_full,
  output logic  rsp_push,
  output resp_t rsp_out
);

  // word index width; the user keeps the depth a power of two, unenforced
  localparam int IDX_W = $clog2(MEM_WORDS);

  logic [63:0]      word_store [MEM_WORDS];
  logic [63:0]      rd_data;
  logic [IDX_W-1:0] idx;
  logic             mem_we;
  logic [63:0]      wr_data;

  back_state_t state;
  back_state_t state_next;
  cmd_t        cur;
  cmd_t        cur_next;

  logic        need_resp;
  logic        done;
  logic [63:0] bm;
  logic [63:0] r1;
  logic [63:0] r2;
  logic [63:0] s1;
  logic [63:0] s2;
  logic        s_less;
  logic        u_less;
  logic [63:0] wb;

  assign idx = cur.offset[IDX_W+2:3];

  // byte mask to bit mask
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      bm[i*8 +: 8] = {8{cur.mask[i]}};
    end
  end

  // atomic unit
  always_comb begin
    r1 = rd_data & bm;
    r2 = cur.data & bm;
    if (cur.mask == LOW_LANES_MASK) begin
      s1 = {{32{r1[31]}}, r1[31:0]};
      s2 = {{32{r2[31]}}, r2[31:0]};
    end else begin
      s1 = r1;
      s2 = r2;
    end
    s_less = ($signed(s1) < $signed(s2));
    u_less = (r1 < r2);
    if (cur.arith) begin
      unique case (cur.param)
        ARITH_MIN:  wb = s_less ? s1 : s2;
        ARITH_MAX:  wb = s_less ? s2 : s1;
        ARITH_MINU: wb = u_less ? r1 : r2;
        ARITH_MAXU: wb = u_less ? r2 : r1;
        ARITH_ADD:  wb = r1 + r2;
        default:    wb = '0;
      endcase
    end else begin
      unique case (cur.param)
        LOGIC_XOR:  wb = r1 ^ r2;
        LOGIC_OR:   wb = r1 | r2;
        LOGIC_AND:  wb = r1 & r2;
        LOGIC_SWAP: wb = r2;
        default:    wb = '0;
      endcase
    end
  end

  // response contents
  always_comb begin
    rsp_out.resp_size   = cur.size;
    rsp_out.resp_source = cur.source;
    unique case (cur.op)
      CMD_WRITE: begin
        need_resp         = cur.last;
        rsp_out.resp_kind = RESP_ACK;
        rsp_out.resp_data = '0;
        rsp_out.last_beat = 1'b1;
        wr_data           = (rd_data & ~bm) | (cur.data & bm);
      end
      CMD_ATOMIC: begin
        need_resp         = 1'b1;
        rsp_out.resp_kind = RESP_ACK_DATA;
        rsp_out.resp_data = rd_data;
        rsp_out.last_beat = cur.last;
        wr_data           = (rd_data & ~bm) | (wb & bm);
      end
      CMD_READ: begin
        need_resp         = 1'b1;
        rsp_out.resp_kind = RESP_ACK_DATA;
        rsp_out.resp_data = rd_data;
        rsp_out.last_beat = (cur.beats == 4'd1);
        wr_data           = rd_data;
      end
      default: begin
        need_resp         = 1'b1;
        rsp_out.resp_kind = RESP_HINT_ACK;
        rsp_out.resp_data = '0;
        rsp_out.last_beat = 1'b1;
        wr_data           = rd_data;
      end
    endcase
    done = !need_resp || !rsp_full;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (done) begin
          state_next = (cur.op == CMD_READ && cur.beats > 4'd1) ? ST_FETCH : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd_pop  = 1'b0;
    rsp_push = 1'b0;
    mem_we   = 1'b0;
    cur_next = cur;
    unique case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop  = 1'b1;
          cur_next = cmd_in;
        end
      end
      ST_EXEC: begin
        if (done) begin
          rsp_push = need_resp;
          mem_we   = (cur.op == CMD_WRITE || cur.op == CMD_ATOMIC);
          if (cur.op == CMD_READ) begin
            cur_next.offset = cur.offset + ADDR_STEP;
            cur_next.beats  = cur.beats - 4'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // state and current command
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
  end

  // word store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      word_store[idx] <= wr_data;
    end
    rd_data <= word_store[idx];
  end

endmodule

// File: hw/rtl/bus_memory_slave_with_atomics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_memory_slave_with_atomics
// Memory slave with burst get/put, atomics and hints over a 64-bit store.
// ----------------------------------------------------------------------------
// each request word passes the command queue and the back end's idle, fetch
//   and exec states, the read-then-write on the store; each get beat repeats
//   fetch and exec; a new command is popped only back in idle
// reset: synchronous rst empties both queues, clears burst state and the
//   base register; store contents are not cleared
module bus_memory_slave_with_atomics
  import bmsa_pkg::*;
#(
  parameter int MEM_WORDS     = 4096,
  parameter int MAX_SIZE_LOG2 = 6,
  parameter int CMD_DEPTH     = 2,
  parameter int RSP_DEPTH     = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  req_t        req,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output resp_t       rsp,
  input  logic        cfg_write,
  input  logic [30:0] cfg_data
);

  logic [30:0] base_address;
  logic        cmd_push;
  cmd_t        cmd_w;
  logic        cmd_full;
  logic        cmd_empty;
  cmd_t        cmd_r;
  logic        cmd_pop;
  logic        rsp_full;
  logic        rsp_push;
  resp_t       rsp_w;

  // base register
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
    end else if (cfg_write) begin
      base_address <= cfg_data;
    end
  end

  // front end
  bmsa_front #(
    .MAX_SIZE_LOG2(MAX_SIZE_LOG2)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .req         (req),
    .full        (full),
    .base_address(base_address),
    .cmd_full    (cmd_full),
    .cmd_push    (cmd_push),
    .cmd         (cmd_w)
  );

  // command queue
  bmsa_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_push),
    .wdata(cmd_w),
    .full (cmd_full),
    .pop  (cmd_pop),
    .rdata(cmd_r),
    .empty(cmd_empty)
  );

  // back end
  bmsa_back #(
    .MEM_WORDS(MEM_WORDS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_empty(cmd_empty),
    .cmd_in   (cmd_r),
    .cmd_pop  (cmd_pop),
    .rsp_full (rsp_full),
    .rsp_push (rsp_push),
    .rsp_out  (rsp_w)
  );

  // response queue
  bmsa_fifo #(
    .WIDTH($bits(resp_t)),
    .DEPTH(RSP_DEPTH)
  ) u_rsp_q (
    .clk  (clk),
    .rst  (rst),
    .push (rsp_push),
    .wdata(rsp_w),
    .full (rsp_full),
    .pop  (pop),
    .rdata(rsp),
    .empty(empty)
  );

endmodule

// File: hw/rtl/bmsa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmsa_checker
// Port-level checks for the bus memory slave, bound to the top level.
// ----------------------------------------------------------------------------
module bmsa_checker
  import bmsa_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        push,
  input req_t        req,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input resp_t       rsp,
  input logic        cfg_write,
  input logic [30:0] cfg_data
);

  // no response words right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("response queue not empty after reset");

  // request side open right after reset
  a_reset_open: assert property (@(posedge clk) rst |=> !full)
    else $error("request side full after reset");

  // a waiting response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(rsp))
    else $error("waiting response word changed");

  // hint and put acks are single final words without data
  a_ack_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && rsp.resp_kind != RESP_ACK_DATA) |-> (rsp.last_beat && rsp.resp_data == '0))
    else $error("ack word without last flag or with data");

endmodule

bind bus_memory_slave_with_atomics bmsa_checker u_checker (.*);
